// File: src/least_overlap_rect_placement_assert.svh
// Assertion macros shared by the placement block.
`ifndef LEAST_OVERLAP_RECT_PLACEMENT_ASSERT_SVH
`define LEAST_OVERLAP_RECT_PLACEMENT_ASSERT_SVH
// Same-cycle implication, disabled during reset.
`define LORP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled during reset.
`define LORP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: src/lorp_pkg.sv
// Shared constants and types of the least-overlap placement block.
package lorp_pkg;
    localparam int MAX_RECTS  = 32;
    localparam int MAX_EDGES  = 66;
    localparam int COORD_BITS = 16;
    localparam int SIZE_BITS  = COORD_BITS - 1;
    localparam int CW         = COORD_BITS + 2;
    localparam int RA_W       = $clog2(MAX_RECTS);
    localparam int RC_W       = $clog2(MAX_RECTS + 1);
    localparam int EI_W       = $clog2(MAX_EDGES);
    localparam int EC_W       = $clog2(MAX_EDGES + 1);
    localparam int COST_W     = 2 * SIZE_BITS + RC_W;

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic [SIZE_BITS-1:0]         w;
        logic [SIZE_BITS-1:0]         h;
    } t_rect;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord w;
        t_coord h;
    } t_box;

    typedef struct packed {
        logic start;
        t_box box;
    } t_cost_req;

    typedef struct packed {
        logic   vld;
        logic   less;
        t_coord val;
    } t_edge_link;
endpackage

// File: src/least_overlap_rect_placement.sv
// Top level of the least-overlap window placement block.
//
// Rectangles load one beat per cycle into a 32-entry store. The beat that
// carries last_rect starts a placement; o_ready stays low until its result
// is loaded into the output register. A placement clears and seeds the edge
// chains, then reads each stored rectangle in turn to build the sorted x and
// y edge lists (one insert per chain per cycle), then runs one cost pass for
// every grid candidate that fits the bound (the cost unit reads, overlaps,
// multiplies and accumulates each stored rectangle in turn) and skips the
// others. The walk stops at the first zero-cost candidate. Centering adds a
// lower-bound scan over the edges on each axis and one cost pass per grow
// step. The result is the window's top-left corner, wrapped to 16 bits.
// Configuration sits on an APB-style port, registers at byte offsets 4*i,
// sampled while the placement runs.
`include "least_overlap_rect_placement_assert.svh"
module least_overlap_rect_placement (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_rect_present,
    input  logic signed [lorp_pkg::COORD_BITS-1:0] i_rect_x,
    input  logic signed [lorp_pkg::COORD_BITS-1:0] i_rect_y,
    input  logic [lorp_pkg::SIZE_BITS-1:0]      i_rect_width,
    input  logic [lorp_pkg::SIZE_BITS-1:0]      i_rect_height,
    input  logic                                i_last_rect,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [lorp_pkg::COORD_BITS-1:0] o_place_x,
    output logic signed [lorp_pkg::COORD_BITS-1:0] o_place_y,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [4:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    typedef enum logic [2:0] {
        REG_BX, REG_BY, REG_BW, REG_BH, REG_WW, REG_WH, REG_CM
    } t_reg_idx;

    typedef enum logic [4:0] {
        S_IDLE, S_CLR, S_BE0, S_BE1, S_RRD, S_RE0, S_RE1, S_WINIT, S_CAND,
        S_CWAIT, S_POST, S_LX, S_LY, S_GX, S_GXW, S_GY, S_GYW, S_CENT, S_FIN
    } t_state;

    localparam int CW   = lorp_pkg::CW;
    localparam int ECW  = lorp_pkg::EC_W;
    localparam int EIW  = lorp_pkg::EI_W;

    // configuration
    logic signed [lorp_pkg::COORD_BITS-1:0] r_bx, r_by;
    logic [lorp_pkg::SIZE_BITS-1:0]         r_bw, r_bh, r_ww, r_wh;
    logic                                   r_cm;
    lorp_pkg::t_coord w_bx, w_by, w_bw, w_bh, w_ww, w_wh;

    // control and working registers
    t_state                      r_state;
    logic [lorp_pkg::RC_W-1:0]   r_cnt, r_k;
    logic [ECW-1:0]              r_i, r_j, r_gi, r_ri, r_bi;
    logic [1:0]                  r_d;
    logic [lorp_pkg::COST_W-1:0] r_best;
    lorp_pkg::t_coord            r_cx, r_cy, r_px, r_py;
    lorp_pkg::t_coord            r_w0, r_h0, r_gw, r_gh;
    logic                        r_xgrew, r_ygrew;
    logic                        r_ovld;
    logic signed [lorp_pkg::COORD_BITS-1:0] r_ox, r_oy;

    // chain and cost-unit hookup
    logic             w_xclr, w_yclr, w_xins, w_yins;
    lorp_pkg::t_coord w_xv, w_yv, w_xl, w_yl;
    logic [ECW-1:0]   w_xidx, w_yidx, w_xcnt, w_ycnt, w_xsc, w_ysc, w_gi1;
    lorp_pkg::t_rect  w_rd;
    lorp_pkg::t_coord w_qx, w_qy, w_qr, w_qb;
    logic             w_qmeet;
    lorp_pkg::t_box   w_cand, w_fx, w_fy;
    logic             w_cand_fit, w_gx_ok, w_gy_ok;
    lorp_pkg::t_cost_req w_req;
    logic             w_cost_busy, w_cost_done, w_wr_en;
    logic [lorp_pkg::COST_W-1:0] w_cost;
    logic             w_adv_go, w_adv_stop, w_cfg_wr, w_acc_in;
    lorp_pkg::t_coord w_fw, w_fh;
    t_reg_idx         w_ridx;

    function automatic logic f_fit(lorp_pkg::t_box b);
        return (b.x >= w_bx) && (b.x + b.w <= w_bx + w_bw) &&
               (b.y >= w_by) && (b.y + b.h <= w_by + w_bh);
    endfunction

    // signed halving, rounding toward zero
    function automatic lorp_pkg::t_coord f_half(lorp_pkg::t_coord v);
        lorp_pkg::t_coord t;
        t = v + lorp_pkg::t_coord'(v[CW-1]);
        return t >>> 1;
    endfunction

    assign w_bx = lorp_pkg::t_coord'(r_bx);
    assign w_by = lorp_pkg::t_coord'(r_by);
    assign w_bw = lorp_pkg::t_coord'(r_bw);
    assign w_bh = lorp_pkg::t_coord'(r_bh);
    assign w_ww = lorp_pkg::t_coord'(r_ww);
    assign w_wh = lorp_pkg::t_coord'(r_wh);

    assign o_ready   = (r_state == S_IDLE);
    assign o_valid   = r_ovld;
    assign o_place_x = r_ox;
    assign o_place_y = r_oy;
    assign pready    = 1'b1;
    assign w_ridx    = t_reg_idx'(paddr[4:2]);
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_acc_in  = i_valid && o_ready;
    assign w_wr_en   = w_acc_in && i_rect_present &&
                       (r_cnt < lorp_pkg::RC_W'(lorp_pkg::MAX_RECTS));

    always_comb begin
        prdata = '0;
        case (w_ridx)
            REG_BX:  prdata[lorp_pkg::COORD_BITS-1:0] = r_bx;
            REG_BY:  prdata[lorp_pkg::COORD_BITS-1:0] = r_by;
            REG_BW:  prdata[lorp_pkg::SIZE_BITS-1:0]  = r_bw;
            REG_BH:  prdata[lorp_pkg::SIZE_BITS-1:0]  = r_bh;
            REG_WW:  prdata[lorp_pkg::SIZE_BITS-1:0]  = r_ww;
            REG_WH:  prdata[lorp_pkg::SIZE_BITS-1:0]  = r_wh;
            REG_CM:  prdata[0]                        = r_cm;
            default: prdata = '0;
        endcase
    end

    // stored rectangle read back during edge build
    assign w_qx    = lorp_pkg::t_coord'(w_rd.x);
    assign w_qy    = lorp_pkg::t_coord'(w_rd.y);
    assign w_qr    = w_qx + lorp_pkg::t_coord'(w_rd.w);
    assign w_qb    = w_qy + lorp_pkg::t_coord'(w_rd.h);
    assign w_qmeet = (w_qx < w_bx + w_bw) && (w_bx < w_qr) &&
                     (w_qy < w_by + w_bh) && (w_by < w_qb);

    // lower-bound scan index, clamped to the last edge
    assign w_xsc = (r_gi >= w_xcnt) ? ECW'(w_xcnt - 1'b1) : r_gi;
    assign w_ysc = (r_gi >= w_ycnt) ? ECW'(w_ycnt - 1'b1) : r_gi;
    assign w_gi1 = ECW'(r_gi + 1'b1);

    always_comb begin
        w_cand.x = w_xl - (r_d[1] ? w_ww : '0);
        w_cand.y = w_yl - (r_d[0] ? w_wh : '0);
        w_cand.w = w_ww;
        w_cand.h = w_wh;
        w_fx     = '{x: r_cx, y: r_cy, w: w_xl - r_cx, h: r_h0};
        w_fy     = '{x: r_cx, y: r_cy, w: r_w0, h: w_yl - r_cy};
    end

    assign w_cand_fit = f_fit(w_cand);
    assign w_gx_ok    = (w_gi1 < w_xcnt) && f_fit(w_fx);
    assign w_gy_ok    = (w_gi1 < w_ycnt) && f_fit(w_fy);

    always_comb begin
        w_xclr = 1'b0;
        w_yclr = 1'b0;
        w_xins = 1'b0;
        w_yins = 1'b0;
        w_xv   = w_bx;
        w_yv   = w_by;
        w_xidx = r_i;
        w_yidx = r_j;
        w_req  = '0;
        case (r_state)
            S_CLR: begin
                w_xclr = 1'b1;
                w_yclr = 1'b1;
            end
            S_BE0: begin
                w_xins = 1'b1;
                w_yins = 1'b1;
            end
            S_BE1: begin
                w_xins = 1'b1;
                w_yins = 1'b1;
                w_xv   = w_bx + w_bw;
                w_yv   = w_by + w_bh;
            end
            S_RE0: begin
                w_xins = w_qmeet;
                w_yins = w_qmeet;
                w_xv   = w_qx;
                w_yv   = w_qy;
            end
            S_RE1: begin
                w_xins = w_qmeet;
                w_yins = w_qmeet;
                w_xv   = w_qr;
                w_yv   = w_qb;
            end
            S_CAND: begin
                w_req.start = w_cand_fit;
                w_req.box   = w_cand;
            end
            S_LX: w_xidx = w_xsc;
            S_LY: w_yidx = w_ysc;
            S_GX: begin
                w_xidx      = w_gi1;
                w_req.start = w_gx_ok;
                w_req.box   = w_fx;
            end
            S_GXW: w_xidx = w_gi1;
            S_GY: begin
                w_yidx      = w_gi1;
                w_req.start = w_gy_ok;
                w_req.box   = w_fy;
            end
            S_GYW: w_yidx = w_gi1;
            default: ;
        endcase
    end

    // walk step: done with one candidate, either skipped or costed
    assign w_adv_go   = ((r_state == S_CAND) && !w_cand_fit) ||
                        ((r_state == S_CWAIT) && w_cost_done);
    assign w_adv_stop = ((r_state == S_CWAIT) && (w_cost == '0)) ||
                        ((r_d == 2'd3) && (r_j == ECW'(w_ycnt - 1'b1)) &&
                         (r_i == ECW'(w_xcnt - 1'b1)));

    // field size after growing along at most one axis
    assign w_fw = (r_xgrew && !r_ygrew) ? r_gw : r_w0;
    assign w_fh = (!r_xgrew && r_ygrew) ? r_gh : r_h0;

    lorp_edge_chain u_xchain (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (w_xclr),
        .i_ins_req (w_xins),
        .i_val     (w_xv),
        .i_rd_idx  (w_xidx[EIW-1:0]),
        .o_rd_val  (w_xl),
        .o_cnt     (w_xcnt)
    );

    lorp_edge_chain u_ychain (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (w_yclr),
        .i_ins_req (w_yins),
        .i_val     (w_yv),
        .i_rd_idx  (w_yidx[EIW-1:0]),
        .o_rd_val  (w_yl),
        .o_cnt     (w_ycnt)
    );

    lorp_cost u_cost (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_cnt[lorp_pkg::RA_W-1:0]),
        .i_wr_data ('{x: i_rect_x, y: i_rect_y, w: i_rect_width, h: i_rect_height}),
        .i_rd_addr (r_k[lorp_pkg::RA_W-1:0]),
        .o_rd_data (w_rd),
        .i_cnt     (r_cnt),
        .i_req     (w_req),
        .o_busy    (w_cost_busy),
        .o_done    (w_cost_done),
        .o_cost    (w_cost)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ovld  <= 1'b0;
            r_bx    <= '0;
            r_by    <= '0;
            r_bw    <= lorp_pkg::SIZE_BITS'(1024);
            r_bh    <= lorp_pkg::SIZE_BITS'(768);
            r_ww    <= lorp_pkg::SIZE_BITS'(1);
            r_wh    <= lorp_pkg::SIZE_BITS'(1);
            r_cm    <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                case (w_ridx)
                    REG_BX:  r_bx <= pwdata[lorp_pkg::COORD_BITS-1:0];
                    REG_BY:  r_by <= pwdata[lorp_pkg::COORD_BITS-1:0];
                    REG_BW:  r_bw <= pwdata[lorp_pkg::SIZE_BITS-1:0];
                    REG_BH:  r_bh <= pwdata[lorp_pkg::SIZE_BITS-1:0];
                    REG_WW:  r_ww <= pwdata[lorp_pkg::SIZE_BITS-1:0];
                    REG_WH:  r_wh <= pwdata[lorp_pkg::SIZE_BITS-1:0];
                    REG_CM:  r_cm <= pwdata[0];
                    default: ;
                endcase
            end
            if (r_ovld && i_ready) begin
                r_ovld <= 1'b0;
            end
            if (w_adv_go) begin
                if (w_adv_stop) begin
                    r_state <= S_POST;
                end else begin
                    r_state <= S_CAND;
                    r_d     <= r_d + 1'b1;
                    if (r_d == 2'd3) begin
                        if (r_j == ECW'(w_ycnt - 1'b1)) begin
                            r_j <= '0;
                            r_i <= r_i + 1'b1;
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc_in) begin
                        if (w_wr_en) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                        if (i_last_rect) begin
                            r_state <= S_CLR;
                        end
                    end
                end
                S_CLR: r_state <= S_BE0;
                S_BE0: r_state <= S_BE1;
                S_BE1: begin
                    r_k     <= '0;
                    r_state <= (r_cnt == '0) ? S_WINIT : S_RRD;
                end
                S_RRD: r_state <= S_RE0;
                S_RE0: r_state <= S_RE1;
                S_RE1: begin
                    r_k     <= r_k + 1'b1;
                    r_state <= (lorp_pkg::RC_W'(r_k + 1'b1) == r_cnt) ? S_WINIT : S_RRD;
                end
                S_WINIT: begin
                    r_best  <= '1;
                    r_cx    <= w_bx;
                    r_cy    <= w_by;
                    r_i     <= '0;
                    r_j     <= '0;
                    r_d     <= '0;
                    r_state <= S_CAND;
                end
                S_CAND: begin
                    r_px <= w_cand.x;
                    r_py <= w_cand.y;
                    if (w_cand_fit) begin
                        r_state <= S_CWAIT;
                    end
                end
                S_CWAIT: begin
                    if (w_cost_done && (w_cost < r_best)) begin
                        r_best <= w_cost;
                        r_cx   <= r_px;
                        r_cy   <= r_py;
                    end
                end
                S_POST: begin
                    r_gi    <= '0;
                    r_state <= (r_cm && (r_best == '0)) ? S_LX : S_FIN;
                end
                S_LX: begin
                    if ((r_gi < w_xcnt) && (w_xl < r_cx + w_ww)) begin
                        r_gi <= r_gi + 1'b1;
                    end else begin
                        r_ri    <= w_xsc;
                        r_w0    <= w_xl - r_cx;
                        r_gi    <= '0;
                        r_state <= S_LY;
                    end
                end
                S_LY: begin
                    if ((r_gi < w_ycnt) && (w_yl < r_cy + w_wh)) begin
                        r_gi <= r_gi + 1'b1;
                    end else begin
                        r_bi    <= w_ysc;
                        r_h0    <= w_yl - r_cy;
                        r_gi    <= r_ri;
                        r_gw    <= r_w0;
                        r_xgrew <= 1'b0;
                        r_state <= S_GX;
                    end
                end
                S_GX: begin
                    if (w_gx_ok) begin
                        r_state <= S_GXW;
                    end else begin
                        r_gi    <= r_bi;
                        r_gh    <= r_h0;
                        r_ygrew <= 1'b0;
                        r_state <= S_GY;
                    end
                end
                S_GXW: begin
                    if (w_cost_done) begin
                        if (w_cost == '0) begin
                            r_gi    <= w_gi1;
                            r_gw    <= w_fx.w;
                            r_xgrew <= 1'b1;
                            r_state <= S_GX;
                        end else begin
                            r_gi    <= r_bi;
                            r_gh    <= r_h0;
                            r_ygrew <= 1'b0;
                            r_state <= S_GY;
                        end
                    end
                end
                S_GY: begin
                    r_state <= w_gy_ok ? S_GYW : S_CENT;
                end
                S_GYW: begin
                    if (w_cost_done) begin
                        if (w_cost == '0) begin
                            r_gi    <= w_gi1;
                            r_gh    <= w_fy.h;
                            r_ygrew <= 1'b1;
                            r_state <= S_GY;
                        end else begin
                            r_state <= S_CENT;
                        end
                    end
                end
                S_CENT: begin
                    r_cx    <= r_cx + f_half(w_fw - w_ww);
                    r_cy    <= r_cy + f_half(w_fh - w_wh);
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_ovld || i_ready) begin
                        r_ox    <= r_cx[lorp_pkg::COORD_BITS-1:0];
                        r_oy    <= r_cy[lorp_pkg::COORD_BITS-1:0];
                        r_ovld  <= 1'b1;
                        r_cnt   <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `LORP_ASSERT_IMP(a_idle_cost_quiet, r_state == S_IDLE, !w_cost_busy, "cost unit busy in idle")
    `LORP_ASSERT_IMP(a_done_expected, w_cost_done, (r_state == S_CWAIT) || (r_state == S_GXW) || (r_state == S_GYW), "unexpected cost done")
    `LORP_ASSERT_NXT(a_result_loaded, (r_state == S_FIN) && (!r_ovld || i_ready), o_valid && (r_cnt == '0) && o_ready, "result not loaded")
    `LORP_ASSERT_IMP(a_store_bound, 1'b1, r_cnt <= lorp_pkg::RC_W'(lorp_pkg::MAX_RECTS), "store count overflow")
endmodule

// File: src/lorp_edge_cell.sv
// One cell of the sorted edge chain: holds one edge, shifts right on insert.
module lorp_edge_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_clr,
    input  logic                i_ins,
    input  lorp_pkg::t_coord    i_val,
    input  lorp_pkg::t_edge_link i_prev,
    output lorp_pkg::t_edge_link o_link,
    output logic                o_eq
);
    logic             r_vld;
    lorp_pkg::t_coord r_val;
    logic             w_less;

    assign w_less = r_vld && (r_val < i_val);
    assign o_eq   = r_vld && (r_val == i_val);
    assign o_link = '{vld: r_vld, less: w_less, val: r_val};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_clr) begin
            r_vld <= 1'b0;
        end else if (i_ins) begin
            r_vld <= r_vld | i_prev.vld;
        end
    end

    // new edge lands where the left neighbor is smaller; cells past it shift
    always_ff @(posedge i_clk) begin
        if (i_ins && !w_less) begin
            r_val <= i_prev.less ? i_val : i_prev.val;
        end
    end
endmodule

// File: src/lorp_edge_chain.sv
// Row of edge cells forming a sorted, de-duplicated edge list.
module lorp_edge_chain (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_clr,
    input  logic                        i_ins_req,
    input  lorp_pkg::t_coord            i_val,
    input  logic [lorp_pkg::EI_W-1:0]   i_rd_idx,
    output lorp_pkg::t_coord            o_rd_val,
    output logic [lorp_pkg::EC_W-1:0]   o_cnt
);
    lorp_pkg::t_edge_link        w_links [lorp_pkg::MAX_EDGES];
    logic [lorp_pkg::MAX_EDGES-1:0] w_eq;
    logic                        w_ins;
    logic [lorp_pkg::EC_W-1:0]   r_cnt;

    localparam lorp_pkg::t_edge_link HEAD = '{vld: 1'b1, less: 1'b1, val: '0};

    assign w_ins = i_ins_req && !(|w_eq) &&
                   (r_cnt < lorp_pkg::EC_W'(lorp_pkg::MAX_EDGES));
    assign o_cnt = r_cnt;

    for (genvar k = 0; k < lorp_pkg::MAX_EDGES; k++) begin : g_cell
        lorp_edge_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clr   (i_clr),
            .i_ins   (w_ins),
            .i_val   (i_val),
            .i_prev  ((k == 0) ? HEAD : w_links[(k == 0) ? 0 : k - 1]),
            .o_link  (w_links[k]),
            .o_eq    (w_eq[k])
        );
    end

    always_comb begin
        o_rd_val = '0;
        for (int k = 0; k < lorp_pkg::MAX_EDGES; k++) begin
            if (i_rd_idx == lorp_pkg::EI_W'(k)) begin
                o_rd_val = w_links[k].val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_clr) begin
            r_cnt <= '0;
        end else if (w_ins) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end
endmodule

// File: src/lorp_cost.sv
// Rectangle store and overlap-cost unit: one stored rectangle per step.
module lorp_cost (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [lorp_pkg::RA_W-1:0]     i_wr_addr,
    input  lorp_pkg::t_rect               i_wr_data,
    input  logic [lorp_pkg::RA_W-1:0]     i_rd_addr,
    output lorp_pkg::t_rect               o_rd_data,
    input  logic [lorp_pkg::RC_W-1:0]     i_cnt,
    input  lorp_pkg::t_cost_req           i_req,
    output logic                          o_busy,
    output logic                          o_done,
    output logic [lorp_pkg::COST_W-1:0]   o_cost
);
    typedef enum logic [2:0] {C_IDLE, C_RD, C_OV, C_MUL, C_ACC} t_cstate;

    lorp_pkg::t_rect r_mem [lorp_pkg::MAX_RECTS];
    lorp_pkg::t_rect r_rd;
    t_cstate         r_state;
    logic [lorp_pkg::RC_W-1:0]        r_k;
    lorp_pkg::t_box                   r_box;
    logic [lorp_pkg::SIZE_BITS-1:0]   r_ow, r_oh;
    logic [2*lorp_pkg::SIZE_BITS-1:0] r_prod;
    logic [lorp_pkg::COST_W-1:0]      r_sum;
    logic                             r_done;
    logic [lorp_pkg::RA_W-1:0]        w_addr;
    lorp_pkg::t_coord w_qx, w_qy, w_qr, w_qb, w_pr, w_pb, w_l, w_t, w_r, w_b, w_ow, w_oh;
    logic w_meet;

    assign w_addr    = (r_state == C_IDLE) ? i_rd_addr : r_k[lorp_pkg::RA_W-1:0];
    assign o_rd_data = r_rd;
    assign o_busy    = (r_state != C_IDLE);
    assign o_done    = r_done;
    assign o_cost    = r_sum;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd <= r_mem[w_addr];
    end

    always_comb begin
        w_qx   = lorp_pkg::t_coord'(r_rd.x);
        w_qy   = lorp_pkg::t_coord'(r_rd.y);
        w_qr   = w_qx + lorp_pkg::t_coord'(r_rd.w);
        w_qb   = w_qy + lorp_pkg::t_coord'(r_rd.h);
        w_pr   = r_box.x + r_box.w;
        w_pb   = r_box.y + r_box.h;
        w_meet = (r_box.x < w_qr) && (w_qx < w_pr) && (r_box.y < w_qb) && (w_qy < w_pb);
        w_l    = (r_box.x > w_qx) ? r_box.x : w_qx;
        w_t    = (r_box.y > w_qy) ? r_box.y : w_qy;
        w_r    = (w_pr < w_qr) ? w_pr : w_qr;
        w_b    = (w_pb < w_qb) ? w_pb : w_qb;
        w_ow   = w_r - w_l;
        w_oh   = w_b - w_t;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                C_IDLE: begin
                    if (i_req.start) begin
                        r_box <= i_req.box;
                        r_sum <= '0;
                        r_k   <= '0;
                        if (i_cnt == '0) begin
                            r_done <= 1'b1;
                        end else begin
                            r_state <= C_RD;
                        end
                    end
                end
                C_RD: r_state <= C_OV;
                C_OV: begin
                    r_ow    <= w_meet ? w_ow[lorp_pkg::SIZE_BITS-1:0] : '0;
                    r_oh    <= w_meet ? w_oh[lorp_pkg::SIZE_BITS-1:0] : '0;
                    r_state <= C_MUL;
                end
                C_MUL: begin
                    r_prod  <= r_ow * r_oh;
                    r_state <= C_ACC;
                end
                C_ACC: begin
                    r_sum <= r_sum + lorp_pkg::COST_W'(r_prod);
                    if (r_k == lorp_pkg::RC_W'(i_cnt - 1'b1)) begin
                        r_done  <= 1'b1;
                        r_state <= C_IDLE;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= C_RD;
                    end
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end
endmodule
